/* rtl/core/bdlp_pkg.sv */
package bdlp_pkg;

  // Number of buttons kept by the block; only those inside the field width are ever seen.
  localparam int unsigned BUTTONS = 3;
  localparam int unsigned FIELD_W = 3;
  localparam int unsigned LANES   = (BUTTONS < FIELD_W) ? BUTTONS : FIELD_W;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_START_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] RST_DEBOUNCE_WINDOW  = 16'd50;
  localparam logic [CFG_W-1:0] RST_LONG_START_DELAY = 16'd500;
  localparam logic [CFG_W-1:0] RST_REPEAT_INTERVAL  = 16'd100;

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [FIELD_W-1:0] changed;
    logic [FIELD_W-1:0] level;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] short_press;
    logic [FIELD_W-1:0] long_start;
    logic [FIELD_W-1:0] long_repeat;
    logic [FIELD_W-1:0] held;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_window;
    logic [CFG_W-1:0] long_start_delay;
    logic [CFG_W-1:0] repeat_interval;
  } bdlp_cfg_t;

  // Per-button event flags produced by one lane.
  typedef struct packed {
    logic short_press;
    logic long_start;
    logic long_repeat;
    logic held;
  } bdlp_lane_res_t;

endpackage

/* rtl/core/bdlp_cfg.sv */
module bdlp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [bdlp_pkg::CFG_W-1:0]     wr_data,
  output bdlp_pkg::bdlp_cfg_t            cfg
);
  import bdlp_pkg::*;

  bdlp_cfg_t cfg_r;
  bdlp_cfg_t cfg_nxt;

  // Decode the register index; unknown indexes leave all registers alone.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE_WINDOW:  cfg_nxt.debounce_window  = wr_data;
        REG_LONG_START_DELAY: cfg_nxt.long_start_delay = wr_data;
        REG_REPEAT_INTERVAL:  cfg_nxt.repeat_interval  = wr_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_window  <= RST_DEBOUNCE_WINDOW;
      cfg_r.long_start_delay <= RST_LONG_START_DELAY;
      cfg_r.repeat_interval  <= RST_REPEAT_INTERVAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/bdlp_lane.sv */
module bdlp_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  bdlp_pkg::bdlp_cfg_t         cfg,
  input  logic [bdlp_pkg::TIME_W-1:0] now_ms,
  input  logic                        chg,
  input  logic                        lvl,
  output bdlp_pkg::bdlp_lane_res_t    res
);
  import bdlp_pkg::*;

  logic              is_pressed_r, is_pressed_nxt;
  logic              in_long_r,    in_long_nxt;
  logic [TIME_W-1:0] press_time_r, press_time_nxt;
  logic [TIME_W-1:0] last_chg_r,   last_chg_nxt;
  logic [TIME_W-1:0] last_rep_r,   last_rep_nxt;

  logic              accept_chg;
  logic              pressed_mid;
  logic              long_mid;
  logic              short_mid;
  logic [TIME_W-1:0] press_time_mid;
  logic [TIME_W-1:0] last_rep_mid;
  logic [TIME_W-1:0] since_chg;
  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] since_rep;

  // Elapsed times wrap modulo 2^32.
  assign since_chg = now_ms - last_chg_r;
  assign accept_chg = chg && (since_chg >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_window});

  // Debounced level change: a high level starts a press, a low level ends it.
  always_comb begin
    pressed_mid    = is_pressed_r;
    long_mid       = in_long_r;
    press_time_mid = press_time_r;
    last_rep_mid   = last_rep_r;
    last_chg_nxt   = last_chg_r;
    short_mid      = 1'b0;
    if (accept_chg) begin
      last_chg_nxt = now_ms;
      long_mid     = 1'b0;
      last_rep_mid = '0;
      if (lvl) begin
        pressed_mid    = 1'b1;
        press_time_mid = now_ms;
      end else begin
        short_mid      = is_pressed_r && !in_long_r;
        pressed_mid    = 1'b0;
        press_time_mid = '0;
      end
    end
  end

  assign since_press = now_ms - press_time_mid;
  assign since_rep   = now_ms - last_rep_mid;

  // Long press start and auto-repeat for a held button.
  always_comb begin
    is_pressed_nxt  = pressed_mid;
    in_long_nxt     = long_mid;
    press_time_nxt  = press_time_mid;
    last_rep_nxt    = last_rep_mid;
    res.short_press = short_mid;
    res.long_start  = 1'b0;
    res.long_repeat = 1'b0;
    res.held        = pressed_mid;
    if (pressed_mid) begin
      if (!long_mid) begin
        if (since_press >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_start_delay}) begin
          in_long_nxt    = 1'b1;
          last_rep_nxt   = now_ms;
          res.long_start = 1'b1;
        end
      end else if (since_rep >= {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_interval}) begin
        last_rep_nxt    = now_ms;
        res.long_repeat = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_pressed_r <= 1'b0;
      in_long_r    <= 1'b0;
      press_time_r <= '0;
      last_chg_r   <= '0;
      last_rep_r   <= '0;
    end else if (en) begin
      is_pressed_r <= is_pressed_nxt;
      in_long_r    <= in_long_nxt;
      press_time_r <= press_time_nxt;
      last_chg_r   <= last_chg_nxt;
      last_rep_r   <= last_rep_nxt;
    end
  end

endmodule

/* rtl/core/button_debounce_long_press_repeat_unit.sv */
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_data   (now_ms, changed, level)
// out_      output     out_valid / out_ready  out_data  (short_press, long_start,
//                                                        long_repeat, held)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One poll per cycle while the result is not stalled: a poll is held in the input register,
// and the per-button lanes update their state and load the result register in the cycle
// it moves on. A poll passes through the input register, then the result register, to out_.
// Synchronous active-low reset clears all button state and loads the default timings.
// A stalled result holds the input register; a new poll is taken whenever it can move on.
// Configuration writes are taken every cycle.
module button_debounce_long_press_repeat_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bdlp_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bdlp_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0]     cfg_data
);
  import bdlp_pkg::*;

  in_item_t   in_r;
  logic       in_vld_r;
  out_item_t  out_r, out_nxt;
  logic       out_vld_r;
  logic       advance;
  bdlp_cfg_t  cfg;
  bdlp_lane_res_t lane_res [LANES];

  // The input register moves on when the result register is free or being emptied.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  bdlp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // One lane per button visible in the fields.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bdlp_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (advance),
      .cfg    (cfg),
      .now_ms (in_r.now_ms),
      .chg    (in_r.changed[i]),
      .lvl    (in_r.level[i]),
      .res    (lane_res[i])
    );
  end

  // Gather lane flags into the result item; bits without a lane stay low.
  always_comb begin
    out_nxt = '0;
    for (int unsigned i = 0; i < LANES; i++) begin
      out_nxt.short_press[i] = lane_res[i].short_press;
      out_nxt.long_start[i]  = lane_res[i].long_start;
      out_nxt.long_repeat[i] = lane_res[i].long_repeat;
      out_nxt.held[i]        = lane_res[i].held;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // A long start or repeat only happens on a button that is still held.
  a_events_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((out_data.long_start | out_data.long_repeat) & ~out_data.held) == '0))
    else $error("long press event on a button that is not held");

  // A short press means the button was released in this poll.
  a_short_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.short_press & out_data.held) == '0))
    else $error("short press reported on a held button");

  // Long start and repeat never coincide on one button.
  a_start_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.long_start & out_data.long_repeat) == '0))
    else $error("long start and repeat in the same poll");

  // Every poll that leaves the input register shows up as a result.
  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("poll moved on without a result");

endmodule

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdlp_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int POLLS_PER_PHASE = 88;
  localparam int RANDOM_PHASES   = 8;

  // Tracks button state from accepted polls and checks every result transfer in order.
  class poll_scoreboard;
    logic [CFG_W-1:0]  window_ms;
    logic [CFG_W-1:0]  long_delay_ms;
    logic [CFG_W-1:0]  repeat_ms;
    bit                pressed [LANES];
    bit                long_active [LANES];
    logic [TIME_W-1:0] press_at [LANES];
    logic [TIME_W-1:0] last_change_at [LANES];
    logic [TIME_W-1:0] last_repeat_at [LANES];
    out_item_t         expected_q [$];
    int                errors;

    function new();
      window_ms     = RST_DEBOUNCE_WINDOW;
      long_delay_ms = RST_LONG_START_DELAY;
      repeat_ms     = RST_REPEAT_INTERVAL;
      errors        = 0;
      for (int b = 0; b < LANES; b++) begin
        pressed[b]        = 1'b0;
        long_active[b]    = 1'b0;
        press_at[b]       = '0;
        last_change_at[b] = '0;
        last_repeat_at[b] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_DEBOUNCE_WINDOW:  window_ms     = val;
        REG_LONG_START_DELAY: long_delay_ms = val;
        REG_REPEAT_INTERVAL:  repeat_ms     = val;
        default: ;
      endcase
    endfunction

    // Works out the events of one accepted poll and queues them.
    function void note_poll(in_item_t p);
      out_item_t         res;
      logic [TIME_W-1:0] elapsed;
      res = '0;
      // Debounced level changes first.
      for (int b = 0; b < LANES; b++) begin
        elapsed = p.now_ms - last_change_at[b];
        if (p.changed[b] && elapsed >= {16'd0, window_ms}) begin
          last_change_at[b] = p.now_ms;
          if (p.level[b]) begin
            pressed[b]  = 1'b1;
            press_at[b] = p.now_ms;
          end else begin
            if (pressed[b] && !long_active[b]) res.short_press[b] = 1'b1;
            pressed[b]  = 1'b0;
            press_at[b] = '0;
          end
          long_active[b]    = 1'b0;
          last_repeat_at[b] = '0;
        end
      end
      // Then long-press start and repeat timing for every held button.
      for (int b = 0; b < LANES; b++) begin
        if (pressed[b]) begin
          if (!long_active[b]) begin
            elapsed = p.now_ms - press_at[b];
            if (elapsed >= {16'd0, long_delay_ms}) begin
              long_active[b]    = 1'b1;
              last_repeat_at[b] = p.now_ms;
              res.long_start[b] = 1'b1;
            end
          end else begin
            elapsed = p.now_ms - last_repeat_at[b];
            if (elapsed >= {16'd0, repeat_ms}) begin
              last_repeat_at[b]  = p.now_ms;
              res.long_repeat[b] = 1'b1;
            end
          end
          res.held[b] = 1'b1;
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.short_press !== want.short_press) begin
        $display("%0t: short_press expected %b actual %b", $time, want.short_press,
                 got.short_press);
        errors++;
      end
      if (got.long_start !== want.long_start) begin
        $display("%0t: long_start expected %b actual %b", $time, want.long_start,
                 got.long_start);
        errors++;
      end
      if (got.long_repeat !== want.long_repeat) begin
        $display("%0t: long_repeat expected %b actual %b", $time, want.long_repeat,
                 got.long_repeat);
        errors++;
      end
      if (got.held !== want.held) begin
        $display("%0t: held expected %b actual %b", $time, want.held, got.held);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  poll_scoreboard    sb = new();
  int                tx_idle_pct = 9;
  int                rx_idle_pct = 85;
  int                hold_cycles = 0;
  int                cycle_count = 0;
  logic [TIME_W-1:0] now_t = '0;
  logic [FIELD_W-1:0] btn_level = '0;

  button_debounce_long_press_repeat_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watch all three channels and feed every transfer to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_poll(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Result receiver: a requested hold-off is counted down here before random stalls resume.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one poll, idling for a random number of cycles first, and wait for its transfer.
  task automatic send_poll(input in_item_t p);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic poll_at(input logic [TIME_W-1:0] t, input logic [FIELD_W-1:0] chg,
                         input logic [FIELD_W-1:0] lvl);
    in_item_t p;
    p.now_ms  = t;
    p.changed = chg;
    p.level   = lvl;
    now_t     = t;
    btn_level = lvl;
    send_poll(p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] dly,
                            input logic [CFG_W-1:0] rep);
    write_reg(REG_DEBOUNCE_WINDOW, deb);
    write_reg(REG_LONG_START_DELAY, dly);
    write_reg(REG_REPEAT_INTERVAL, rep);
  endtask

  // Stop offering polls and wait until every expected result has arrived.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly clean toggles on a moving clock, sometimes random masks and large time jumps.
  task automatic gen_poll(output in_item_t p);
    int                 pick;
    logic [FIELD_W-1:0] chg;
    pick = $urandom_range(0, 99);
    if (pick < 40) now_t = now_t + $urandom_range(0, 64);
    else if (pick < 70) now_t = now_t + $urandom_range(0, 600);
    else if (pick < 85) now_t = now_t + $urandom_range(0, 5000);
    else if (pick < 95) now_t = now_t + $urandom_range(0, 70000);
    else now_t = $urandom();
    chg = '0;
    if ($urandom_range(0, 99) < 85) begin
      for (int b = 0; b < LANES; b++) begin
        if ($urandom_range(0, 99) < 30) chg[b] = 1'b1;
      end
      btn_level = btn_level ^ chg;
      p.changed = chg;
      p.level   = btn_level;
    end else begin
      p.changed = FIELD_W'($urandom_range(0, 7));
      p.level   = FIELD_W'($urandom_range(0, 7));
      btn_level = p.level;
    end
    p.now_ms = now_t;
  endtask

  initial begin
    in_item_t p;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed polls at the reset timings (50 / 500 / 100).
    poll_at(32'd10, 3'b001, 3'b001);          // dropped: inside the window after reset
    poll_at(32'd100, 3'b111, 3'b111);         // all three pressed
    poll_at(32'd120, 3'b001, 3'b000);         // bounce, dropped
    poll_at(32'd200, 3'b001, 3'b000);         // short press on button 0
    poll_at(32'd300, 3'b010, 3'b010);         // press restart on button 1
    poll_at(32'd300, 3'b000, 3'b000);
    poll_at(32'd700, 3'b000, 3'b000);         // long start on button 2
    poll_at(32'd800, 3'b000, 3'b000);         // repeat 2, long start 1
    poll_at(32'd850, 3'b000, 3'b000);
    poll_at(32'd900, 3'b000, 3'b000);         // repeats on 1 and 2
    poll_at(32'd1000, 3'b100, 3'b000);        // release during long press, silent
    poll_at(32'd1100, 3'b001, 3'b000);        // low while not pressed
    poll_at(32'hFFFF_FFF0, 3'b001, 3'b001);   // press just before wrap
    poll_at(32'h0000_0200, 3'b000, 3'b000);   // long start across the wrap
    poll_at(32'hFFFF_FFFF, 3'b111, 3'b000);   // release everything at the top
    drain();

    // Zero timings: long start on the press poll, then a repeat every poll.
    set_timing(16'd0, 16'd0, 16'd0);
    poll_at(32'd5000, 3'b111, 3'b111);
    poll_at(32'd5000, 3'b000, 3'b111);
    poll_at(32'd5001, 3'b010, 3'b101);
    poll_at(32'd5001, 3'b111, 3'b010);
    drain();

    // Largest timings: the first change falls inside the window and is swallowed.
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    poll_at(32'd5100, 3'b111, 3'b111);
    poll_at(32'd5100 + 32'd65535, 3'b111, 3'b111);
    poll_at(32'd5100 + 32'd131070, 3'b000, 3'b111);
    poll_at(32'd5100 + 32'd196605, 3'b000, 3'b111);
    poll_at(32'd5100 + 32'd262140, 3'b111, 3'b000);
    drain();

    // Random phases over several timing settings and idle patterns.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_timing(16'd0, 16'd0, 16'd0);
        1: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_timing(RST_DEBOUNCE_WINDOW, RST_LONG_START_DELAY, RST_REPEAT_INTERVAL);
        3: set_timing(16'd0, 16'hFFFF, 16'd0);
        7: set_timing(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()));
        default: set_timing(CFG_W'($urandom_range(0, 80)), CFG_W'($urandom_range(0, 400)),
                            CFG_W'($urandom_range(0, 150)));
      endcase
      if (ph < 3) begin
        tx_idle_pct = 9;
        rx_idle_pct = 85;
      end else if (ph < 6) begin
        tx_idle_pct = 85;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int n = 0; n < POLLS_PER_PHASE; n++) begin
        // Long receiver hold-off while polls keep coming, so the input stalls.
        if ((ph == 6 && n == 20) || (ph == 7 && n == 40)) hold_cycles = HOLD_OFF_CYCLES;
        gen_poll(p);
        send_poll(p);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* button_debounce_long_press_repeat_unit.f */
rtl/core/bdlp_pkg.sv
rtl/core/bdlp_cfg.sv
rtl/core/bdlp_lane.sv
rtl/core/button_debounce_long_press_repeat_unit.sv
sim/tb_top.sv
